@@ sv/dfsts_pkg.sv @@
// Shared constants for the depth-first topological sort block.
// No dependencies; imported by dfsts_scan and dfs_topological_sort.
`timescale 1ns / 1ps

package dfsts_pkg;

	localparam int MAX_VERTICES_DEF = 32;  // default vertex capacity
	localparam int ROW_W            = 32;  // adjacency row width on the input port
	localparam int VC_W             = 6;   // vertex_count register width
	localparam int IDX_W            = 5;   // row_index, position and vertex width

	localparam logic [VC_W-1:0] VC_RESET = 6'd32;

endpackage

@@ sv/dfs_topological_sort.sv @@
// Top level: row loading, depth-first search sequencer, order buffer and result output.
// Depends on dfsts_pkg and dfsts_scan.
//
//   channel   ports                                   direction  transfer when
//   ------    -------------------------------------   ---------  --------------------
//   command   start, busy, row_index, row_bits,        in         start & !busy
//             last_row
//   result    done, position, vertex, last            out        done (one cycle)
//   config    cfg_valid, cfg_ready, cfg_data          in         cfg_valid & cfg_ready
//
// A row without last_row is stored and busy stays low.
// A last_row command runs the search: a setup step, an outer vertex test per vertex,
// and per vertex a push (row fetch, scan) and a pop (scan, stack read), each
// paced by the registered reads of the adjacency and stack memories.
// Emission then reads the order buffer through a registered read, one result per cycle.
// The receiver cannot stall results. arst_n clears the sequencer; no clearing pass.
`timescale 1ns / 1ps

module dfs_topological_sort import dfsts_pkg::*; #(
	parameter  int MAX_VERTICES = MAX_VERTICES_DEF,
	localparam int VW           = $clog2(MAX_VERTICES),
	localparam int NW           = $clog2(MAX_VERTICES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [IDX_W-1:0] row_index,
	input  logic [ROW_W-1:0] row_bits,
	input  logic             last_row,
	output logic             done,
	output logic [IDX_W-1:0] position,
	output logic [IDX_W-1:0] vertex,
	output logic             last,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [VC_W-1:0]  cfg_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INIT  = 3'd1;
	localparam logic [2:0] S_OUTER = 3'd2;
	localparam logic [2:0] S_FETCH = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_POP   = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	typedef struct packed {
		logic [VW-1:0] v;
		logic [NW-1:0] j;
	} frame_t;

	logic [2:0]              state_q;
	logic [VC_W-1:0]         vc_q;
	logic [NW-1:0]           n_q;
	logic [NW-1:0]           i_q;
	logic [NW-1:0]           k_q;
	logic [NW-1:0]           depth_q;
	logic [VW-1:0]           fill_q;
	logic [MAX_VERTICES-1:0] visited_q;
	frame_t                  top_q;
	frame_t                  pop_q;
	logic [ROW_W-1:0]        row_q;
	logic [VW-1:0]           ord_rd_q;
	logic [NW-1:0]           pos_q;
	logic                    last_q;
	logic                    done_q;

	logic [ROW_W-1:0]        adj_mem [MAX_VERTICES];
	frame_t                  stack_mem [MAX_VERTICES];
	logic [VW-1:0]           order_mem [MAX_VERTICES];

	logic                    cmd_xfer;
	logic                    row_in_range;
	logic                    scan_found;
	logic [VW-1:0]           scan_idx;
	logic                    push_ok;
	logic [NW-1:0]           n_eff;

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = ~busy;
	assign cmd_xfer     = start & ~busy;
	assign row_in_range = (32'(row_index) < MAX_VERTICES);
	assign push_ok      = scan_found & (32'(depth_q) < MAX_VERTICES);

	always_comb begin
		if (vc_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(vc_q) > MAX_VERTICES) begin
			n_eff = NW'(MAX_VERTICES);
		end else begin
			n_eff = NW'(vc_q);
		end
	end

	dfsts_scan #(
		.WIDTH(MAX_VERTICES)
	) u_scan (
		.row    (row_q),
		.visited(visited_q),
		.from   (top_q.j),
		.limit  (n_q),
		.found  (scan_found),
		.index  (scan_idx)
	);

	// adjacency rows: one write port (loading), one registered read (search)
	always_ff @(posedge clk) begin
		if (cmd_xfer && row_in_range) begin
			adj_mem[VW'(row_index)] <= row_bits;
		end
		if (state_q == S_FETCH) begin
			row_q <= adj_mem[top_q.v];
		end else if (state_q == S_POP) begin
			row_q <= adj_mem[pop_q.v];
		end
	end

	// search stack below the top frame, which lives in top_q
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && push_ok) begin
			stack_mem[depth_q[VW-1:0] - VW'(1)] <= '{v: top_q.v, j: NW'(scan_idx) + NW'(1)};
		end
		if (state_q == S_SCAN) begin
			pop_q <= stack_mem[depth_q[VW-1:0] - VW'(2)];
		end
	end

	// order buffer, filled from the last slot downward
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && !push_ok) begin
			order_mem[fill_q] <= top_q.v;
		end
		if (state_q == S_EMIT) begin
			ord_rd_q <= order_mem[k_q[VW-1:0]];
			pos_q    <= k_q;
			last_q   <= (k_q == n_q - NW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			vc_q      <= VC_RESET;
			n_q       <= NW'(MAX_VERTICES);
			i_q       <= '0;
			k_q       <= '0;
			depth_q   <= '0;
			fill_q    <= VW'(MAX_VERTICES - 1);
			visited_q <= '0;
			top_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= (state_q == S_EMIT);
			if (cfg_valid && cfg_ready) begin
				vc_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_xfer && last_row) begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					n_q       <= n_eff;
					fill_q    <= VW'(n_eff - NW'(1));
					visited_q <= '0;
					depth_q   <= '0;
					i_q       <= '0;
					state_q   <= S_OUTER;
				end
				S_OUTER: begin
					if (i_q == n_q) begin
						k_q     <= '0;
						state_q <= S_EMIT;
					end else if (visited_q[i_q[VW-1:0]]) begin
						i_q <= i_q + NW'(1);
					end else begin
						visited_q[i_q[VW-1:0]] <= 1'b1;
						top_q   <= '{v: i_q[VW-1:0], j: '0};
						depth_q <= NW'(1);
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (push_ok) begin
						visited_q[scan_idx] <= 1'b1;
						top_q   <= '{v: scan_idx, j: '0};
						depth_q <= depth_q + NW'(1);
						state_q <= S_FETCH;
					end else begin
						// finish the top vertex and drop its frame
						if (fill_q != '0) begin
							fill_q <= fill_q - VW'(1);
						end
						depth_q <= depth_q - NW'(1);
						state_q <= (depth_q == NW'(1)) ? S_OUTER : S_POP;
					end
				end
				S_POP: begin
					top_q   <= pop_q;
					state_q <= S_SCAN;
				end
				S_EMIT: begin
					if (k_q == n_q - NW'(1)) begin
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q + NW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign position = IDX_W'(pos_q);
	assign vertex   = IDX_W'(ord_rd_q);
	assign last     = last_q;

	a_done_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == S_EMIT)
		else $error("result strobe without an emit cycle");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(depth_q) <= MAX_VERTICES)
		else $error("search stack overflow");

	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_row) |=> state_q == S_INIT)
		else $error("last row transfer did not start a run");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && last_q) |=> !done_q)
		else $error("result after the last vertex");

	a_pop_has_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> depth_q != '0)
		else $error("pop from an empty stack");

endmodule

@@ sv/dfsts_scan.sv @@
// Neighbor search unit: lowest unvisited neighbor at or above a start index and below a limit.
// Depends on dfsts_pkg; used by the scan step of the search sequencer.
`timescale 1ns / 1ps

module dfsts_scan import dfsts_pkg::*; #(
	parameter  int WIDTH = MAX_VERTICES_DEF,
	localparam int VW    = $clog2(WIDTH),
	localparam int NW    = $clog2(WIDTH + 1)
) (
	input  logic [ROW_W-1:0] row,
	input  logic [WIDTH-1:0] visited,
	input  logic [NW-1:0]    from,
	input  logic [NW-1:0]    limit,
	output logic             found,
	output logic [VW-1:0]    index
);

	logic [WIDTH-1:0] row_ext;
	logic [WIDTH-1:0] cand;

	always_comb begin
		row_ext = WIDTH'(row);
		for (int k = 0; k < WIDTH; k++) begin
			cand[k] = row_ext[k] & ~visited[k] & (32'(from) <= k) & (k < 32'(limit));
		end
		found = |cand;
		// priority encode, lowest index wins
		index = '0;
		for (int k = WIDTH - 1; k >= 0; k--) begin
			if (cand[k]) begin
				index = VW'(k);
			end
		end
	end

endmodule
